// ----- rtl/gnsr_pkg.sv -----
// shared constants for the nearest-neighbour glyph row scaler
package gnsr_pkg;

	localparam int CHAN_W   = 8;
	localparam int TEXEL_W  = 4 * CHAN_W;
	localparam int INDEX_W  = 10;
	localparam int PATCH_W  = 7;
	localparam int COL_W    = 6;

	localparam int GLYPH_WIDTH_DEF  = 24;
	localparam int GLYPH_HEIGHT_DEF = 36;
	localparam int PATCH_MAX_DEF    = 64;

	localparam logic [CHAN_W-1:0] OPAQUE_MIN   = 8'd128;
	localparam logic [CHAN_W-1:0] OPAQUE_ALPHA = 8'd255;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_RENDER = 1'b1;

endpackage

// ----- rtl/gnsr_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module gnsr_div #(
	parameter int NUM_W = 12,
	parameter int DEN_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
				num_q  <= num;
				den_q  <= den;
				quo_q  <= '0;
				rem_q  <= '0;
			end else if (busy_q) begin
				num_q <= num_q << 1;
				quo_q <= {quo_q[NUM_W-2:0], ge};
				rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ----- rtl/gnsr_store.sv -----
// glyph texel memory, one write and one registered read port
module gnsr_store #(
	parameter int DEPTH  = 864,
	parameter int ADDR_W = 10
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [ADDR_W-1:0]           wr_addr,
	input  logic [gnsr_pkg::TEXEL_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [ADDR_W-1:0]           rd_addr,
	output logic [gnsr_pkg::TEXEL_W-1:0] rd_data
);

	logic [gnsr_pkg::TEXEL_W-1:0] mem_q [DEPTH];
	logic [gnsr_pkg::TEXEL_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- rtl/glyph_nearest_scale_row.sv -----
// top level: glyph store, shared divider and row sequencer
// a load beat writes the glyph store when its index is in range and emits nothing
// a valid render beat runs two divisions on the shared divider (row, then column step),
// then emits one pixel per cycle from the store read port unless pixel_stall holds the output,
// patch_width pixels in all; bad renders emit nothing; reset clears all registers but not the store
// item_stall is high from a valid render accept until its last store read
module glyph_nearest_scale_row #(
	parameter int GLYPH_WIDTH  = gnsr_pkg::GLYPH_WIDTH_DEF,
	parameter int GLYPH_HEIGHT = gnsr_pkg::GLYPH_HEIGHT_DEF,
	parameter int PATCH_MAX    = gnsr_pkg::PATCH_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          func,
	input  logic [gnsr_pkg::INDEX_W-1:0]  texel_index,
	input  logic [gnsr_pkg::CHAN_W-1:0]   texel_red,
	input  logic [gnsr_pkg::CHAN_W-1:0]   texel_green,
	input  logic [gnsr_pkg::CHAN_W-1:0]   texel_blue,
	input  logic [gnsr_pkg::CHAN_W-1:0]   texel_alpha,
	input  logic [gnsr_pkg::PATCH_W-1:0]  patch_width,
	input  logic [gnsr_pkg::PATCH_W-1:0]  patch_height,
	input  logic [gnsr_pkg::COL_W-1:0]    row_index,
	output logic                          pixel_valid,
	input  logic                          pixel_stall,
	output logic [gnsr_pkg::CHAN_W-1:0]   out_red,
	output logic [gnsr_pkg::CHAN_W-1:0]   out_green,
	output logic [gnsr_pkg::CHAN_W-1:0]   out_blue,
	output logic [gnsr_pkg::CHAN_W-1:0]   out_alpha,
	output logic [gnsr_pkg::COL_W-1:0]    pixel_column,
	output logic                          last_in_row
);

	localparam int DEPTH    = GLYPH_WIDTH * GLYPH_HEIGHT;
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int GX_W     = $clog2(GLYPH_WIDTH + 1);
	localparam int ROWN_W   = gnsr_pkg::COL_W + $clog2(GLYPH_HEIGHT + 1);
	localparam int NUM_W    = (ROWN_W > GX_W) ? ROWN_W : GX_W;
	localparam int PW       = gnsr_pkg::PATCH_W;
	localparam int CW       = gnsr_pkg::CHAN_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROW,
		ST_COL,
		ST_EMIT
	} state_t;

	state_t                      state_q;
	logic                        accept;
	logic                        render_ok;
	logic                        wr_en;
	logic [gnsr_pkg::TEXEL_W-1:0] wr_data;
	logic [gnsr_pkg::TEXEL_W-1:0] rd_data;
	logic [ADDR_W-1:0]           rd_addr;
	logic                        issue;
	logic                        adv_s1;

	logic                        div_start_q;
	logic [NUM_W-1:0]            div_num_q;
	logic [PW-1:0]               div_den_q;
	logic                        div_done;
	logic [NUM_W-1:0]            div_quo;
	logic [PW-1:0]               div_rem;
	logic [ADDR_W-1:0]           base_d;

	logic [PW-1:0]               pw_q;
	logic [ADDR_W-1:0]           base_q;
	logic [GX_W-1:0]             q0_q;
	logic [PW-1:0]               r0_q;
	logic [GX_W-1:0]             gx_q;
	logic [PW-1:0]               rem_q;
	logic [gnsr_pkg::COL_W-1:0]  x_q;
	logic                        last_x;
	logic [PW:0]                 rem_sum;
	logic                        rem_ge;
	logic [PW:0]                 rem_sub;
	logic [GX_W:0]               gx_sum;

	logic                        v_s1;
	logic [gnsr_pkg::COL_W-1:0]  col_s1;
	logic                        last_s1;
	logic                        opaque;

	logic                        pixel_valid_q;
	logic [CW-1:0]               red_q;
	logic [CW-1:0]               green_q;
	logic [CW-1:0]               blue_q;
	logic [CW-1:0]               alpha_q;
	logic [gnsr_pkg::COL_W-1:0]  col_q;
	logic                        last_q;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	assign render_ok = (patch_width != '0) && (patch_height != '0)
		&& (patch_width <= PW'(PATCH_MAX)) && (patch_height <= PW'(PATCH_MAX))
		&& ({1'b0, row_index} < patch_height);

	assign wr_en   = accept && (func == gnsr_pkg::FUNC_LOAD) && (32'(texel_index) < DEPTH);
	assign wr_data = {texel_alpha, texel_blue, texel_green, texel_red};

	assign rd_addr = base_q + ADDR_W'(gx_q);
	assign adv_s1  = v_s1 && (!pixel_valid_q || !pixel_stall);
	assign issue   = (state_q == ST_EMIT) && (!v_s1 || adv_s1);

	assign base_d  = ADDR_W'(div_quo * GLYPH_WIDTH);
	assign last_x  = ({1'b0, x_q} + PW'(1)) == pw_q;
	assign rem_sum = {1'b0, rem_q} + {1'b0, r0_q};
	assign rem_ge  = rem_sum >= {1'b0, pw_q};
	assign rem_sub = rem_sum - {1'b0, pw_q};
	assign gx_sum  = {1'b0, gx_q} + {1'b0, q0_q} + (GX_W + 1)'(rem_ge);

	assign opaque  = rd_data[gnsr_pkg::TEXEL_W-1 -: CW] >= gnsr_pkg::OPAQUE_MIN;

	gnsr_div #(
		.NUM_W (NUM_W),
		.DEN_W (PW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	gnsr_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ADDR_W'(texel_index)),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			div_start_q   <= 1'b0;
			div_num_q     <= '0;
			div_den_q     <= '0;
			pw_q          <= '0;
			base_q        <= '0;
			q0_q          <= '0;
			r0_q          <= '0;
			gx_q          <= '0;
			rem_q         <= '0;
			x_q           <= '0;
			v_s1          <= 1'b0;
			col_s1        <= '0;
			last_s1       <= 1'b0;
			pixel_valid_q <= 1'b0;
			red_q         <= '0;
			green_q       <= '0;
			blue_q        <= '0;
			alpha_q       <= '0;
			col_q         <= '0;
			last_q        <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (func == gnsr_pkg::FUNC_RENDER) && render_ok) begin
						pw_q        <= patch_width;
						div_num_q   <= NUM_W'(row_index * GLYPH_HEIGHT);
						div_den_q   <= patch_height;
						div_start_q <= 1'b1;
						state_q     <= ST_ROW;
					end
				end
				ST_ROW: begin
					if (div_done) begin
						base_q      <= base_d;
						div_num_q   <= NUM_W'(GLYPH_WIDTH);
						div_den_q   <= pw_q;
						div_start_q <= 1'b1;
						state_q     <= ST_COL;
					end
				end
				ST_COL: begin
					if (div_done) begin
						q0_q    <= div_quo[GX_W-1:0];
						r0_q    <= div_rem;
						gx_q    <= '0;
						rem_q   <= '0;
						x_q     <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (issue) begin
						gx_q  <= gx_sum[GX_W-1:0];
						rem_q <= rem_ge ? rem_sub[PW-1:0] : rem_sum[PW-1:0];
						x_q   <= x_q + 1'b1;
						if (last_x) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// read stage
			if (issue) begin
				v_s1    <= 1'b1;
				col_s1  <= x_q;
				last_s1 <= last_x;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end

			// output beat register
			if (adv_s1) begin
				pixel_valid_q <= 1'b1;
				red_q         <= opaque ? rd_data[0 +: CW] : '0;
				green_q       <= opaque ? rd_data[CW +: CW] : '0;
				blue_q        <= opaque ? rd_data[2*CW +: CW] : '0;
				alpha_q       <= opaque ? gnsr_pkg::OPAQUE_ALPHA : '0;
				col_q         <= col_s1;
				last_q        <= last_s1;
			end else if (!pixel_stall) begin
				pixel_valid_q <= 1'b0;
			end
		end
	end

	assign pixel_valid  = pixel_valid_q;
	assign out_red      = red_q;
	assign out_green    = green_q;
	assign out_blue     = blue_q;
	assign out_alpha    = alpha_q;
	assign pixel_column = col_q;
	assign last_in_row  = last_q;

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (32'(rd_addr) < DEPTH))
		else $error("store read beyond glyph");

	a_rem_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (rem_q < pw_q))
		else $error("column remainder not below patch width");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == ST_ROW) || (state_q == ST_COL)))
		else $error("divider finished outside a division step");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s1) |=> (v_s1 && $stable(col_s1) && $stable(last_s1)))
		else $error("read stage lost a stalled pixel");

	a_last_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && last_x) |=> (state_q == ST_IDLE))
		else $error("row did not end after last column");

endmodule

// ----- dv/glyph_nearest_scale_row_test.sv -----
// self-checking testbench for the glyph row scaler with a texel-store predictor and random stalls
module glyph_nearest_scale_row_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GLYPH_WIDTH  = gnsr_pkg::GLYPH_WIDTH_DEF;
	localparam int GLYPH_HEIGHT = gnsr_pkg::GLYPH_HEIGHT_DEF;
	localparam int PATCH_MAX    = gnsr_pkg::PATCH_MAX_DEF;
	localparam int INDEX_W      = gnsr_pkg::INDEX_W;
	localparam int CHAN_W       = gnsr_pkg::CHAN_W;
	localparam int PATCH_W      = gnsr_pkg::PATCH_W;
	localparam int COL_W        = gnsr_pkg::COL_W;
	localparam int TEXEL_W      = gnsr_pkg::TEXEL_W;
	localparam int GLYPH_TEXELS = GLYPH_WIDTH * GLYPH_HEIGHT;
	localparam int RANDOM_BEATS = 90;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 120;
	localparam int LIMIT_CYCLES = 600000;

	typedef struct packed {
		logic               func;
		logic [INDEX_W-1:0] texel_index;
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic [CHAN_W-1:0]  alpha;
		logic [PATCH_W-1:0] patch_width;
		logic [PATCH_W-1:0] patch_height;
		logic [COL_W-1:0]   row_index;
	} beat_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
		logic [COL_W-1:0]  column;
		logic              last;
	} pixel_t;

	typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_HEAVY, SINK_PERIODIC} sink_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic func = gnsr_pkg::FUNC_LOAD;
	logic [INDEX_W-1:0] texel_index = '0;
	logic [CHAN_W-1:0] texel_red = '0;
	logic [CHAN_W-1:0] texel_green = '0;
	logic [CHAN_W-1:0] texel_blue = '0;
	logic [CHAN_W-1:0] texel_alpha = '0;
	logic [PATCH_W-1:0] patch_width = '0;
	logic [PATCH_W-1:0] patch_height = '0;
	logic [COL_W-1:0] row_index = '0;
	logic pixel_valid;
	logic pixel_stall = 1'b0;
	logic [CHAN_W-1:0] out_red;
	logic [CHAN_W-1:0] out_green;
	logic [CHAN_W-1:0] out_blue;
	logic [CHAN_W-1:0] out_alpha;
	logic [COL_W-1:0] pixel_column;
	logic last_in_row;

	logic [TEXEL_W-1:0] glyph_texels [GLYPH_TEXELS];
	pixel_t pending_pixels [$];
	int fail_count = 0;
	int load_beats = 0;
	int render_beats = 0;
	int pixels_checked = 0;
	int hold_requests = 0;
	int cycle_count = 0;

	glyph_nearest_scale_row DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func(func),
		.texel_index(texel_index),
		.texel_red(texel_red),
		.texel_green(texel_green),
		.texel_blue(texel_blue),
		.texel_alpha(texel_alpha),
		.patch_width(patch_width),
		.patch_height(patch_height),
		.row_index(row_index),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.out_alpha(out_alpha),
		.pixel_column(pixel_column),
		.last_in_row(last_in_row)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("glyph_nearest_scale_row_test failed");
			$finish;
		end
	end

	task automatic predict_row(input beat_t b);
		int src_row;
		int src_col;
		logic [TEXEL_W-1:0] texel;
		pixel_t p;
		if (b.func == gnsr_pkg::FUNC_LOAD) begin
			load_beats++;
			if (b.texel_index < GLYPH_TEXELS)
				glyph_texels[b.texel_index] = {b.alpha, b.blue, b.green, b.red};
			return;
		end
		render_beats++;
		if (b.patch_width == 0 || b.patch_height == 0 || b.patch_width > PATCH_MAX ||
				b.patch_height > PATCH_MAX || b.row_index >= b.patch_height)
			return;
		src_row = int'(b.row_index) * GLYPH_HEIGHT / int'(b.patch_height);
		for (int x = 0; x < int'(b.patch_width); x++) begin
			src_col = x * GLYPH_WIDTH / int'(b.patch_width);
			texel = glyph_texels[src_row * GLYPH_WIDTH + src_col];
			p = '0;
			if (texel[31:24] >= gnsr_pkg::OPAQUE_MIN) begin
				p.red = texel[7:0];
				p.green = texel[15:8];
				p.blue = texel[23:16];
				p.alpha = gnsr_pkg::OPAQUE_ALPHA;
			end
			p.column = x[COL_W-1:0];
			p.last = (x + 1 == int'(b.patch_width));
			pending_pixels.push_back(p);
		end
	endtask

	task automatic send_beat(input beat_t b);
		item_valid <= 1'b1;
		func <= b.func;
		texel_index <= b.texel_index;
		texel_red <= b.red;
		texel_green <= b.green;
		texel_blue <= b.blue;
		texel_alpha <= b.alpha;
		patch_width <= b.patch_width;
		patch_height <= b.patch_height;
		row_index <= b.row_index;
		do @(posedge clk); while (item_stall);
		predict_row(b);
	endtask

	task automatic idle(input int cycles);
		if (cycles > 0) begin
			item_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	function automatic beat_t noise_beat();
		beat_t b;
		b = $bits(beat_t)'({$urandom, $urandom});
		return b;
	endfunction

	function automatic beat_t make_load(input int idx, input int r, input int g, input int bl,
			input int a);
		beat_t b;
		b = noise_beat();
		b.func = gnsr_pkg::FUNC_LOAD;
		b.texel_index = idx[INDEX_W-1:0];
		b.red = r[CHAN_W-1:0];
		b.green = g[CHAN_W-1:0];
		b.blue = bl[CHAN_W-1:0];
		b.alpha = a[CHAN_W-1:0];
		return b;
	endfunction

	function automatic beat_t make_render(input int pw, input int ph, input int row);
		beat_t b;
		b = noise_beat();
		b.func = gnsr_pkg::FUNC_RENDER;
		b.patch_width = pw[PATCH_W-1:0];
		b.patch_height = ph[PATCH_W-1:0];
		b.row_index = row[COL_W-1:0];
		return b;
	endfunction

	function automatic int bad_size();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(PATCH_MAX + 1, 127);
	endfunction

	function automatic beat_t valid_render();
		int pw;
		int ph;
		pw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, PATCH_MAX) : $urandom_range(1, 16);
		ph = $urandom_range(1, PATCH_MAX);
		return make_render(pw, ph, $urandom_range(0, ph - 1));
	endfunction

	initial begin : pixel_sink
		sink_mode_t mode;
		int mode_left;
		int hold_left;
		int served;
		mode = SINK_OPEN;
		mode_left = 0;
		hold_left = 0;
		served = 0;
		forever begin
			@(posedge clk);
			if (served != hold_requests) begin
				served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				pixel_stall <= 1'b1;
			end else begin
				case (mode)
					SINK_OPEN: pixel_stall <= 1'b0;
					SINK_RANDOM: pixel_stall <= 1'($urandom_range(0, 1));
					SINK_HEAVY: pixel_stall <= ($urandom_range(0, 3) != 0);
					default: pixel_stall <= (mode_left % 5) < 2;
				endcase
			end
		end
	end

	task automatic check_field(input string name, input int expected, input int actual);
		if (expected != actual) begin
			$error("%s mismatch: expected %0d, got %0d", name, expected, actual);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : pixel_check
		pixel_t p;
		if (arst_n && pixel_valid && !pixel_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel beat with no expected pixel, column %0d", pixel_column);
				fail_count++;
			end else begin
				p = pending_pixels.pop_front();
				check_field("out_red", int'(p.red), int'(out_red));
				check_field("out_green", int'(p.green), int'(out_green));
				check_field("out_blue", int'(p.blue), int'(out_blue));
				check_field("out_alpha", int'(p.alpha), int'(out_alpha));
				check_field("pixel_column", int'(p.column), int'(pixel_column));
				check_field("last_in_row", int'(p.last), int'(last_in_row));
				pixels_checked++;
			end
		end
	end

	task automatic test_glyph_preload();
		for (int i = 0; i < GLYPH_TEXELS; i++) begin
			send_beat(make_load(i, $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255)));
			if ($urandom_range(0, 15) == 0)
				idle($urandom_range(1, 4));
		end
	endtask

	task automatic test_patch_extremes();
		send_beat(make_render(1, 1, 0));
		send_beat(make_render(PATCH_MAX, PATCH_MAX, PATCH_MAX - 1));
		send_beat(make_render(GLYPH_WIDTH, GLYPH_HEIGHT, GLYPH_HEIGHT - 1));
		send_beat(make_render(1, PATCH_MAX, 0));
		send_beat(make_render(PATCH_MAX, 1, 0));
	endtask

	task automatic test_alpha_threshold();
		send_beat(make_load(0, 255, 255, 255, int'(gnsr_pkg::OPAQUE_MIN) - 1));
		send_beat(make_render(1, 1, 0));
		send_beat(make_load(0, 255, 255, 255, int'(gnsr_pkg::OPAQUE_MIN)));
		send_beat(make_render(1, 1, 0));
		send_beat(make_load(0, 0, 0, 0, 255));
		send_beat(make_render(1, 1, 0));
		send_beat(make_load(0, 255, 0, 255, 0));
		send_beat(make_render(1, 1, 0));
	endtask

	task automatic test_ignored_items();
		send_beat(make_load(GLYPH_TEXELS, 255, 255, 255, 255));
		send_beat(make_load(1023, 255, 255, 255, 255));
		send_beat(make_render(GLYPH_WIDTH, GLYPH_HEIGHT, GLYPH_HEIGHT - 1));
		send_beat(make_render(0, 8, 0));
		send_beat(make_render(8, 0, 0));
		send_beat(make_render(PATCH_MAX + 1, 8, 0));
		send_beat(make_render(8, 127, 0));
		send_beat(make_render(127, 127, 63));
		send_beat(make_render(8, 63, 63));
		send_beat(make_render(8, 5, 5));
		idle(2);
	endtask

	task automatic test_random_traffic();
		int useful;
		int burst_left;
		int pick;
		beat_t b;
		useful = 0;
		burst_left = 0;
		while (useful < RANDOM_BEATS) begin
			if (burst_left == 0) begin
				idle($urandom_range(0, 6));
				burst_left = $urandom_range(1, 16);
			end
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				b = make_load($urandom_range(0, GLYPH_TEXELS - 1), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
				useful++;
			end else if (pick < 40) begin
				b = make_load($urandom_range(GLYPH_TEXELS, 1023), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
			end else if (pick < 90) begin
				b = valid_render();
				useful++;
			end else begin
				case ($urandom_range(0, 2))
					0: b = make_render(bad_size(), $urandom_range(1, PATCH_MAX), 0);
					1: b = make_render($urandom_range(1, PATCH_MAX), bad_size(), 0);
					default: begin
						b = make_render($urandom_range(1, PATCH_MAX), $urandom_range(1, 63), 0);
						b.row_index = COL_W'($urandom_range(b.patch_height, 63));
					end
				endcase
			end
			send_beat(b);
			burst_left--;
		end
	endtask

	task automatic test_backpressure();
		hold_requests <= hold_requests + 1;
		for (int i = 0; i < 8; i++)
			send_beat(make_render(PATCH_MAX, $urandom_range(1, PATCH_MAX), 0));
		for (int i = 0; i < 6; i++)
			send_beat(make_load($urandom_range(0, GLYPH_TEXELS - 1), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255)));
		send_beat(valid_render());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_glyph_preload();
		test_patch_extremes();
		test_alpha_threshold();
		test_ignored_items();
		test_random_traffic();
		test_backpressure();
		test_random_traffic();
		idle(1);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d texel loads and %0d row renders, %0d pixels compared",
			load_beats, render_beats, pixels_checked);
		$display("included threshold alpha, out-of-range loads, bad sizes and a long output hold");
		if (fail_count == 0)
			$display("glyph_nearest_scale_row_test passed");
		else
			$display("glyph_nearest_scale_row_test failed");
		$finish;
	end

endmodule
